// ===== design/swac_pkg.sv =====
package swac_pkg;

   // Sizing
   localparam int MAX_WINDOW    = 4096;
   localparam int ALPHABET_SIZE = 52;
   localparam int LETTERS       = 26;
   localparam int CODE_W        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int LEN_W         = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int DIFF_W        = $clog2(ALPHABET_SIZE + 1);
   localparam int TOTAL_W       = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // ASCII anchors
   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_Z = 8'h5A;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;

   // Request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_TEXT  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Operation carried down the pipeline
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_TEXT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic              ok;
      logic [CODE_W-1:0] code;
   } code_type;

   typedef struct packed {
      op_type            op;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] old;
      logic              remove;
      logic              full;
      logic              bad;
   } pipe_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] addr;
      logic [LEN_W-1:0]  data;
   } wr_type;

   typedef struct packed {
      logic               window_full;
      logic               window_match;
      logic [TOTAL_W-1:0] match_count;
      logic               bad_request;
   } rsp_type;

   function automatic code_type letter_code(input logic [7:0] symbol);
      logic [7:0] raw;
      code_type   res;
      raw    = '0;
      res.ok = 1'b0;
      if (symbol >= UPPER_A && symbol <= UPPER_Z) begin
         raw    = symbol - UPPER_A;
         res.ok = 1'b1;
      end else if (symbol >= LOWER_A && symbol <= LOWER_Z) begin
         raw    = symbol - LOWER_A + 8'(LETTERS);
         res.ok = 1'b1;
      end
      if (raw >= 8'(ALPHABET_SIZE)) begin
         res.ok = 1'b0;
      end
      res.code = raw[CODE_W-1:0];
      return res;
   endfunction

endpackage

// ===== design/swac_req_if.sv =====
interface swac_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] symbol;

   modport source (output valid, output req_type, output symbol, input ready);
   modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

// ===== design/swac_rsp_if.sv =====
interface swac_rsp_if;
   logic        valid;
   logic        ready;
   logic        window_full;
   logic        window_match;
   logic [31:0] match_count;
   logic        bad_request;

   modport source (output valid, output window_full, output window_match,
                   output match_count, output bad_request, input ready);
   modport sink   (input valid, input window_full, input window_match,
                   input match_count, input bad_request, output ready);
endinterface

// ===== design/swac_ram.sv =====
module swac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int READS = 1,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr [READS],
   output logic [WIDTH-1:0] rd_data [READS]
);

   logic [WIDTH-1:0] mem_ff     [DEPTH];
   logic [WIDTH-1:0] rd_data_ff [READS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-first: a read and write to the same entry return the old word
   always_ff @(posedge clock) begin
      for (int i = 0; i < READS; i++) begin
         rd_data_ff[i] <= mem_ff[rd_addr[i]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/swac_rsp_queue.sv =====
module swac_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swac_pkg::rsp_type       push_data,
   input  logic                    pop_ready,
   output logic                    out_valid,
   output swac_pkg::rsp_type       out_data,
   output logic [swac_pkg::QCNT_W-1:0] count
);
   import swac_pkg::*;

   rsp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/sliding_window_anagram_counter_unit.sv =====
// Sliding-window anagram counter.
// req_bus carries one request per handshake: req_type selects pattern load,
// text letter or clear, symbol is the ASCII letter. rsp_bus returns exactly one
// response per request, in order: window_full, window_match, the saturating
// match_count and bad_request (request rejected, state untouched).
// Load the pattern letters first, then stream text; clear empties everything.
// Pipeline: an accepted request passes the history read, histogram read and
// update/response stages, then the response queue in front of rsp_bus.
// Throughput: one request per cycle while req_bus.ready is high; every text
// letter does a read-modify-write on the 52-entry add RAM, and once the window
// is full also on the 52-entry drop RAM, through one write port each, and one
// read plus one write on the 4096-entry history RAM.
// Stalls: a 4-entry response queue holds finished responses; req_bus.ready drops
// once the requests in flight plus queued responses reach 4, so nothing is lost.
// Reset (synchronous, active high) empties the pipeline and queue and marks all
// histogram entries as zero at once; no clearing pass is needed, and the
// history RAM is only read at entries rewritten since the last clear.
module sliding_window_anagram_counter_unit (
   input logic        clock,
   input logic        reset,
   swac_req_if.sink   req_bus,
   swac_rsp_if.source rsp_bus
);
   import swac_pkg::*;

   // Histogram state is split in two RAMs so each letter needs one write per RAM:
   //   add RAM   holds (window adds - pattern letters) per code
   //   drop RAM  holds window removals per code
   // window - pattern = add - drop (mod 2^LEN_W), zero exactly when counts agree.

   // ---------------- stage 0: accept, control state, history access
   logic                req_fire;
   code_type            in_code;
   logic [LEN_W-1:0]    plen_ff, plen_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]    hptr_ff, hptr_in;
   logic                started_ff, started_in;
   logic                hist_we;
   pipe_type            s0;
   logic [QCNT_W-1:0]   occ;
   logic [QCNT_W-1:0]   q_count;
   logic                s1_valid_ff;
   logic                s2_valid_ff;

   assign occ           = QCNT_W'(s1_valid_ff) + QCNT_W'(s2_valid_ff) + q_count;
   assign req_bus.ready = (occ < QCNT_W'(QUEUE_DEPTH));
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_code       = letter_code(req_bus.symbol);

   always_comb begin
      plen_in    = plen_ff;
      fill_in    = fill_ff;
      hptr_in    = hptr_ff;
      started_in = started_ff;
      hist_we    = 1'b0;
      s0.op      = OP_NONE;
      s0.code    = in_code.code;
      s0.old     = '0;
      s0.remove  = 1'b0;
      s0.full    = (plen_ff != '0) && (fill_ff == plen_ff);
      s0.bad     = 1'b0;
      if (req_fire) begin
         unique case (req_bus.req_type)
            REQ_LOAD: begin
               s0.full = 1'b0;
               if (!in_code.ok || started_ff || plen_ff >= LEN_W'(MAX_WINDOW)) begin
                  s0.bad = 1'b1;
               end else begin
                  s0.op   = OP_LOAD;
                  plen_in = plen_ff + 1'b1;
               end
            end
            REQ_TEXT: begin
               if (!in_code.ok || plen_ff == '0) begin
                  s0.bad = 1'b1;
               end else begin
                  s0.op      = OP_TEXT;
                  started_in = 1'b1;
                  hist_we    = 1'b1;
                  // window still filling: no letter leaves
                  if (fill_ff < plen_ff) begin
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     s0.remove = 1'b1;
                  end
                  s0.full = (fill_in == plen_ff);
                  // ring wraps at the pattern length
                  if (LEN_W'(hptr_ff) + LEN_W'(1) >= plen_ff) begin
                     hptr_in = '0;
                  end else begin
                     hptr_in = hptr_ff + 1'b1;
                  end
               end
            end
            REQ_CLEAR: begin
               s0.op      = OP_CLEAR;
               s0.full    = 1'b0;
               plen_in    = '0;
               fill_in    = '0;
               hptr_in    = '0;
               started_in = 1'b0;
            end
            default: begin
               s0.bad = 1'b1;
            end
         endcase
      end
   end

   // history ring: read the leaving letter and write the new one at one slot
   logic [PTR_W-1:0]  hist_rd_addr [1];
   logic [CODE_W-1:0] hist_rd_data [1];

   assign hist_rd_addr[0] = hptr_ff;

   swac_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_WINDOW),
      .READS (1)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hptr_ff),
      .wr_data (in_code.code),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // ---------------- stage 1: leaving letter known, read both histograms
   pipe_type s1_ff;
   pipe_type s1_out;

   always_comb begin
      s1_out     = s1_ff;
      s1_out.old = hist_rd_data[0];
   end

   logic [CODE_W-1:0] hg_rd_addr [2];
   logic [LEN_W-1:0]  add_rd_data [2];
   logic [LEN_W-1:0]  drop_rd_data [2];

   assign hg_rd_addr[0] = s1_ff.code;
   assign hg_rd_addr[1] = s1_ff.remove ? hist_rd_data[0] : s1_ff.code;

   // ---------------- stage 2: update counts, build response
   pipe_type            s2_ff;
   logic [ALPHABET_SIZE-1:0] add_vld_ff, add_vld_in;
   logic [ALPHABET_SIZE-1:0] drop_vld_ff, drop_vld_in;
   wr_type              add_wr_ff, add_wr_in;
   wr_type              drop_wr_ff, drop_wr_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [LEN_W-1:0]    add_c, add_o, drop_c, drop_o;
   logic [LEN_W-1:0]    dc, d_old;
   logic [1:0]          ups, downs;
   logic                match;
   rsp_type             rsp_word;

   swac_ram #(
      .WIDTH (LEN_W),
      .DEPTH (ALPHABET_SIZE),
      .READS (2)
   ) u_add_ram (
      .clock   (clock),
      .wr_en   (add_wr_in.valid),
      .wr_addr (add_wr_in.addr),
      .wr_data (add_wr_in.data),
      .rd_addr (hg_rd_addr),
      .rd_data (add_rd_data)
   );

   swac_ram #(
      .WIDTH (LEN_W),
      .DEPTH (ALPHABET_SIZE),
      .READS (2)
   ) u_drop_ram (
      .clock   (clock),
      .wr_en   (drop_wr_in.valid),
      .wr_addr (drop_wr_in.addr),
      .wr_data (drop_wr_in.data),
      .rd_addr (hg_rd_addr),
      .rd_data (drop_rd_data)
   );

   // Read data comes from the RAM's read register: the previous cycle's write is forwarded,
   // and entries not written since the last clear read as zero.
   always_comb begin
      add_c  = (add_wr_ff.valid && add_wr_ff.addr == s2_ff.code) ? add_wr_ff.data :
               (add_vld_ff[s2_ff.code] ? add_rd_data[0] : '0);
      add_o  = (add_wr_ff.valid && add_wr_ff.addr == s2_ff.old) ? add_wr_ff.data :
               (add_vld_ff[s2_ff.old] ? add_rd_data[1] : '0);
      drop_c = (drop_wr_ff.valid && drop_wr_ff.addr == s2_ff.code) ? drop_wr_ff.data :
               (drop_vld_ff[s2_ff.code] ? drop_rd_data[0] : '0);
      drop_o = (drop_wr_ff.valid && drop_wr_ff.addr == s2_ff.old) ? drop_wr_ff.data :
               (drop_vld_ff[s2_ff.old] ? drop_rd_data[1] : '0);
      dc     = add_c - drop_c;
      d_old  = add_o - drop_o;
   end

   always_comb begin
      add_wr_in        = '0;
      drop_wr_in       = '0;
      add_wr_in.addr   = s2_ff.code;
      drop_wr_in.addr  = s2_ff.old;
      add_vld_in       = add_vld_ff;
      drop_vld_in      = drop_vld_ff;
      ups              = 2'd0;
      downs            = 2'd0;
      match            = 1'b0;
      diff_in          = diff_ff;
      total_in         = total_ff;
      if (s2_valid_ff) begin
         unique case (s2_ff.op)
            OP_LOAD: begin
               add_wr_in.valid = 1'b1;
               add_wr_in.data  = add_c - 1'b1;
               ups             = 2'(dc == '0);
               downs           = 2'(dc == LEN_W'(1));
            end
            OP_TEXT: begin
               add_wr_in.valid = 1'b1;
               add_wr_in.data  = add_c + 1'b1;
               if (s2_ff.remove) begin
                  drop_wr_in.valid = 1'b1;
                  drop_wr_in.data  = drop_o + 1'b1;
               end
               // same letter in and out leaves the balance unchanged
               if (!s2_ff.remove || s2_ff.old != s2_ff.code) begin
                  ups   = 2'(dc == '0);
                  downs = 2'(dc == '1);
                  if (s2_ff.remove) begin
                     ups   = ups + 2'(d_old == '0);
                     downs = downs + 2'(d_old == LEN_W'(1));
                  end
               end
            end
            OP_CLEAR: begin
               add_vld_in  = '0;
               drop_vld_in = '0;
            end
            default: begin
            end
         endcase
         if (add_wr_in.valid) begin
            add_vld_in[s2_ff.code] = 1'b1;
         end
         if (drop_wr_in.valid) begin
            drop_vld_in[s2_ff.old] = 1'b1;
         end
         diff_in = diff_ff + DIFF_W'(ups) - DIFF_W'(downs);
         match   = (s2_ff.op == OP_TEXT) && s2_ff.full && (diff_in == '0);
         if (s2_ff.op == OP_CLEAR) begin
            diff_in  = '0;
            total_in = '0;
         end else if (match && total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
      end
      rsp_word.window_full  = s2_ff.full;
      rsp_word.window_match = match;
      rsp_word.match_count  = total_in;
      rsp_word.bad_request  = s2_ff.bad;
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff     <= '0;
         fill_ff     <= '0;
         hptr_ff     <= '0;
         started_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         add_vld_ff  <= '0;
         drop_vld_ff <= '0;
         add_wr_ff   <= '0;
         drop_wr_ff  <= '0;
         diff_ff     <= '0;
         total_ff    <= '0;
      end else begin
         plen_ff     <= plen_in;
         fill_ff     <= fill_in;
         hptr_ff     <= hptr_in;
         started_ff  <= started_in;
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
         add_vld_ff  <= add_vld_in;
         drop_vld_ff <= drop_vld_in;
         add_wr_ff   <= add_wr_in;
         drop_wr_ff  <= drop_wr_in;
         diff_ff     <= diff_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s0;
      s2_ff <= s1_out;
   end

   // ---------------- response queue
   rsp_type q_data;
   logic    q_valid;

   swac_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (rsp_word),
      .pop_ready (rsp_bus.ready),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_bus.valid        = q_valid;
   assign rsp_bus.window_full  = q_data.window_full;
   assign rsp_bus.window_match = q_data.window_match;
   assign rsp_bus.match_count  = q_data.match_count;
   assign rsp_bus.bad_request  = q_data.bad_request;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= QCNT_W'(QUEUE_DEPTH))
      else $error("requests in flight exceed response queue space");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plen_ff && plen_ff <= LEN_W'(MAX_WINDOW))
      else $error("window fill or pattern length out of range");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff != '0 |-> LEN_W'(hptr_ff) < plen_ff)
      else $error("history pointer beyond pattern length");

   a_diff_bound: assert property (@(posedge clock) disable iff (reset)
      diff_ff <= DIFF_W'(ALPHABET_SIZE))
      else $error("differing letter count out of range");

   a_clear_ctrl: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.req_type == REQ_CLEAR |=> plen_ff == '0 && !started_ff)
      else $error("clear did not reset pattern state");
`endif

endmodule
